// ----- rtl/core/dtw_pkg.sv -----
// Shared constants, codes and types of the DTW distance unit.
`timescale 1ns / 1ps

package dtw_pkg;

    localparam int MAX_REF_LEN = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int COST_W      = 32;
    localparam int STATUS_W    = 2;

    localparam int ADDR_W = (MAX_REF_LEN > 1) ? $clog2(MAX_REF_LEN) : 1;
    localparam int CNT_W  = $clog2(MAX_REF_LEN + 1);

    localparam logic [COST_W-1:0] COST_INF = {COST_W{1'b1}};

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TRUNC = 2'd2;

    localparam logic OP_REF   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int FQ_DEPTH = 4;
    localparam int FQ_AW    = $clog2(FQ_DEPTH);
    localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

    typedef struct packed {
        logic                          kind;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } t_item;

endpackage

// ----- rtl/core/dtw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dtw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/dtw_front.sv -----
// Input side: accepts words, tags them as reference or query, and queues them.
`timescale 1ns / 1ps

module dtw_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  i_req_type,
    input  logic signed [dtw_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                                  i_last,
    output logic                                  o_item_valid,
    output dtw_pkg::t_item                        o_item,
    input  logic                                  i_item_take
);

    dtw_pkg::t_item              r_mem [dtw_pkg::FQ_DEPTH];
    logic [dtw_pkg::FQ_AW-1:0]   r_wptr;
    logic [dtw_pkg::FQ_AW-1:0]   r_rptr;
    logic [dtw_pkg::FQ_CW-1:0]   r_count;
    logic                        wr;
    logic                        rd;
    dtw_pkg::t_item              in_item;

    assign full         = (r_count == dtw_pkg::FQ_CW'(dtw_pkg::FQ_DEPTH));
    assign o_item_valid = (r_count != '0);
    assign wr           = push && !full;
    assign rd           = i_item_take && o_item_valid;
    assign o_item       = r_mem[r_rptr];

    always_comb begin
        in_item.kind   = i_req_type ? dtw_pkg::OP_QUERY : dtw_pkg::OP_REF;
        in_item.sample = i_sample;
        in_item.last   = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({wr, rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/core/dtw_back.sv -----
// Execution side: stores the reference, walks the cost row per query, holds the result.
`timescale 1ns / 1ps

module dtw_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_item_valid,
    input  dtw_pkg::t_item                       i_item,
    output logic                                 o_item_take,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [dtw_pkg::COST_W-1:0]           o_distance,
    output logic                                 o_saturated,
    output logic [dtw_pkg::STATUS_W-1:0]         o_status
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    localparam int SW = dtw_pkg::SAMPLE_BITS;
    localparam int CW = dtw_pkg::COST_W;
    localparam int AW = dtw_pkg::ADDR_W;
    localparam int NW = dtw_pkg::CNT_W;

    logic [1:0]                   r_state;
    logic [NW-1:0]                r_ref_count;
    logic                         r_row_started;
    logic                         r_ref_done;
    logic                         r_overflow;
    logic                         r_sat;
    logic [NW-1:0]                r_rd_idx;
    logic                         r_v1;
    logic                         r_v2;
    logic                         r_out_valid;

    logic                         r_first;
    logic                         r_last;
    logic signed [SW-1:0]         r_sample;
    logic [AW-1:0]                r_idx1;
    logic [AW-1:0]                r_idx2;
    logic [CW-1:0]                r_prev_up;
    logic [CW-1:0]                r_mud;
    logic [SW-1:0]                r_cost;
    logic [CW-1:0]                r_left;
    logic [CW-1:0]                r_res_dist;
    logic                         r_res_sat;
    logic [dtw_pkg::STATUS_W-1:0] r_res_status;
    logic [CW-1:0]                r_out_dist;
    logic                         r_out_sat;
    logic [dtw_pkg::STATUS_W-1:0] r_out_status;

    logic                         take;
    logic                         start_walk;
    logic                         ref_room;
    logic                         ref_we;
    logic [AW-1:0]                ref_waddr;
    logic                         issue;
    logic signed [SW-1:0]         ref_q;
    logic [CW-1:0]                row_q;
    logic [CW-1:0]                up;
    logic [CW-1:0]                mud;
    logic signed [SW:0]           diff;
    logic [SW:0]                  diff_abs;
    logic [CW-1:0]                cand;
    logic [CW:0]                  sum;
    logic                         c_sat;
    logic [CW-1:0]                cell_cost;
    logic                         final_cell;
    logic                         out_free;

    assign take        = (r_state == S_IDLE) && i_item_valid;
    assign o_item_take = take;
    assign start_walk  = take && (i_item.kind == dtw_pkg::OP_QUERY) && (r_ref_count != '0);

    assign ref_room  = r_ref_done || (r_ref_count < NW'(dtw_pkg::MAX_REF_LEN));
    assign ref_we    = take && (i_item.kind == dtw_pkg::OP_REF) && ref_room;
    assign ref_waddr = r_ref_done ? '0 : r_ref_count[AW-1:0];

    assign issue = (r_state == S_WALK) && (r_rd_idx < r_ref_count);

    dtw_ram #(
        .WIDTH (SW),
        .DEPTH (dtw_pkg::MAX_REF_LEN)
    ) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (ref_we),
        .i_waddr (ref_waddr),
        .i_wdata (i_item.sample),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (ref_q)
    );

    dtw_ram #(
        .WIDTH (CW),
        .DEPTH (dtw_pkg::MAX_REF_LEN)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (r_v2),
        .i_waddr (r_idx2),
        .i_wdata (cell_cost),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (row_q)
    );

    // First stage: the cell above and the diagonal cell, and the local cost.
    always_comb begin
        up       = r_first ? dtw_pkg::COST_INF : row_q;
        mud      = (up < r_prev_up) ? up : r_prev_up;
        diff     = {ref_q[SW-1], ref_q} - {r_sample[SW-1], r_sample};
        diff_abs = diff[SW] ? (SW+1)'(-diff) : (SW+1)'(diff);
    end

    // Second stage: add the cost to the cheapest neighbor and saturate.
    always_comb begin
        cand       = (r_mud < r_left) ? r_mud : r_left;
        sum        = {1'b0, cand} + (CW+1)'(r_cost);
        c_sat      = (sum >= {1'b0, dtw_pkg::COST_INF});
        cell_cost  = c_sat ? dtw_pkg::COST_INF : sum[CW-1:0];
        final_cell = r_v2 && (NW'(r_idx2) == (r_ref_count - 1'b1));
    end

    assign out_free = !r_out_valid || pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ref_count   <= '0;
            r_row_started <= 1'b0;
            r_ref_done    <= 1'b0;
            r_overflow    <= 1'b0;
            r_sat         <= 1'b0;
            r_rd_idx      <= '0;
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            if (issue) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (r_out_valid && pop && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (take) begin
                        if (i_item.kind == dtw_pkg::OP_REF) begin
                            r_ref_done <= i_item.last;
                            if (r_ref_done) begin
                                r_ref_count   <= NW'(1);
                                r_overflow    <= 1'b0;
                                r_row_started <= 1'b0;
                                r_sat         <= 1'b0;
                            end else if (ref_room) begin
                                r_ref_count <= r_ref_count + 1'b1;
                            end else begin
                                r_overflow <= 1'b1;
                            end
                        end else begin
                            r_ref_done <= 1'b1;
                            if (r_ref_count == '0) begin
                                if (i_item.last) begin
                                    r_state <= S_EMIT;
                                end
                            end else begin
                                if (!r_row_started) begin
                                    r_sat <= 1'b0;
                                end
                                r_rd_idx <= '0;
                                r_state  <= S_WALK;
                            end
                        end
                    end
                end
                S_WALK: begin
                    if (final_cell) begin
                        if (r_last) begin
                            r_row_started <= 1'b0;
                            r_sat         <= 1'b0;
                            r_state       <= S_EMIT;
                        end else begin
                            r_row_started <= 1'b1;
                            r_state       <= S_IDLE;
                            if (c_sat) begin
                                r_sat <= 1'b1;
                            end
                        end
                    end else if (r_v2 && c_sat) begin
                        r_sat <= 1'b1;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_walk) begin
            r_first   <= !r_row_started;
            r_last    <= i_item.last;
            r_sample  <= i_item.sample;
            r_prev_up <= r_row_started ? dtw_pkg::COST_INF : '0;
            r_left    <= dtw_pkg::COST_INF;
        end else begin
            if (r_v1) begin
                r_prev_up <= up;
            end
            if (r_v2) begin
                r_left <= cell_cost;
            end
        end
        if (r_v1) begin
            r_mud  <= mud;
            r_cost <= diff_abs[SW-1:0];
            r_idx2 <= r_idx1;
        end
        if (issue) begin
            r_idx1 <= r_rd_idx[AW-1:0];
        end
        if (take && (i_item.kind == dtw_pkg::OP_QUERY) && (r_ref_count == '0)) begin
            r_res_dist   <= '0;
            r_res_sat    <= 1'b0;
            r_res_status <= dtw_pkg::ST_EMPTY;
        end else if (final_cell) begin
            r_res_dist   <= cell_cost;
            r_res_sat    <= r_sat || c_sat;
            r_res_status <= r_overflow ? dtw_pkg::ST_TRUNC : dtw_pkg::ST_OK;
        end
        if ((r_state == S_EMIT) && out_free) begin
            r_out_dist   <= r_res_dist;
            r_out_sat    <= r_res_sat;
            r_out_status <= r_res_status;
        end
    end

    assign empty       = !r_out_valid;
    assign o_distance  = r_out_dist;
    assign o_saturated = r_out_sat;
    assign o_status    = r_out_status;

endmodule

// ----- rtl/core/dtw_distance_unit.sv -----
// Top level of the dynamic time warping distance unit.
`timescale 1ns / 1ps

// Computes the dynamic time warping distance between a stored reference and
// a streamed query, with the absolute sample difference as local cost and a
// saturating 32-bit accumulation. Reference words (req_type 0) are stored one
// per cycle while the unit is idle, up to 1024 samples; extra samples are
// dropped and flagged as truncated. Each query word (req_type 1) walks the
// stored cost row one cell per cycle through a three-stage pipeline around
// the cost-row RAM, and a query word with last set also produces a result
// word. A small input queue lets new words be pushed while a query walks,
// and a result register holds the answer until popped.

module dtw_distance_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  i_req_type,
    input  logic signed [dtw_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                                  i_last,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [dtw_pkg::COST_W-1:0]            o_distance,
    output logic                                  o_saturated,
    output logic [dtw_pkg::STATUS_W-1:0]          o_status
);

    logic           item_valid;
    logic           item_take;
    dtw_pkg::t_item item;

    dtw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_req_type   (i_req_type),
        .i_sample     (i_sample),
        .i_last       (i_last),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_take  (item_take)
    );

    dtw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_take  (item_take),
        .empty        (empty),
        .pop          (pop),
        .o_distance   (o_distance),
        .o_saturated  (o_saturated),
        .o_status     (o_status)
    );

endmodule
